### sv/matrix3x3_inverse_assert.svh
// Assertion macros shared by the 3x3 matrix inverse RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define M3INV_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("m3inv check failed");

// The consequent must hold later than the antecedent, by the delay given as dly.
`define M3INV_ASSERT_DELAY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("m3inv latency check failed");

`endif

### sv/m3inv_pkg.sv
// Package for the 3x3 matrix inverse: operand index tables for the cofactors.
// No dependencies.
`timescale 1ns / 1ps

package m3inv_pkg;

  typedef logic [3:0] idx_t;

  // Cofactor k = m[CA[k]] * m[CB[k]] - m[CC[k]] * m[CD[k]], entries row-major.
  localparam idx_t CA [9] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
  localparam idx_t CB [9] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
  localparam idx_t CC [9] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
  localparam idx_t CD [9] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

  // Output entry (r,c) takes cofactor (c,r).
  localparam idx_t TR [9] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

endpackage

### sv/matrix3x3_inverse.sv
// Top level of the pipelined 3x3 fixed-point matrix inverse.
// Depends on m3inv_pkg and matrix3x3_inverse_assert.svh.
`timescale 1ns / 1ps
`include "matrix3x3_inverse_assert.svh"

// One matrix request is taken in every cycle that start is high; busy is always
// low. Each result appears on done for exactly one cycle and cannot be held off.
// Behind five stages of multiply, cofactor, determinant and magnitude logic
// plus a saturation check, the restoring divider has nine lanes of ENTRY_WIDTH
// pipeline stages, one quotient bit per stage. A zero determinant returns the
// input matrix with singular set.
module matrix3x3_inverse #(
  parameter int ENTRY_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ENTRY_WIDTH-1:0] in_r0c0,
  input  logic signed [ENTRY_WIDTH-1:0] in_r0c1,
  input  logic signed [ENTRY_WIDTH-1:0] in_r0c2,
  input  logic signed [ENTRY_WIDTH-1:0] in_r1c0,
  input  logic signed [ENTRY_WIDTH-1:0] in_r1c1,
  input  logic signed [ENTRY_WIDTH-1:0] in_r1c2,
  input  logic signed [ENTRY_WIDTH-1:0] in_r2c0,
  input  logic signed [ENTRY_WIDTH-1:0] in_r2c1,
  input  logic signed [ENTRY_WIDTH-1:0] in_r2c2,
  output logic                          done,
  output logic signed [ENTRY_WIDTH-1:0] out_r0c0,
  output logic signed [ENTRY_WIDTH-1:0] out_r0c1,
  output logic signed [ENTRY_WIDTH-1:0] out_r0c2,
  output logic signed [ENTRY_WIDTH-1:0] out_r1c0,
  output logic signed [ENTRY_WIDTH-1:0] out_r1c1,
  output logic signed [ENTRY_WIDTH-1:0] out_r1c2,
  output logic signed [ENTRY_WIDTH-1:0] out_r2c0,
  output logic signed [ENTRY_WIDTH-1:0] out_r2c1,
  output logic signed [ENTRY_WIDTH-1:0] out_r2c2,
  output logic                          singular
);

  localparam int W    = ENTRY_WIDTH;
  localparam int PW   = 2 * W;
  localparam int CW   = 2 * W + 1;
  localparam int DPW  = 3 * W + 1;
  localparam int DETW = 3 * W + 3;
  localparam int NW   = CW + 2 * FRAC_BITS;
  localparam int CMPW = (NW > DETW + W) ? NW : DETW + W;
  localparam int NSTG = W + 7;

  // Valid bits travel alongside the data; the pipeline never stalls.
  logic [NSTG-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTG-2:0], start};
    end
  end

  assign busy = 1'b0;
  assign done = vld[NSTG-1];

  logic signed [W-1:0] m_in [0:8];

  assign m_in[0] = in_r0c0;
  assign m_in[1] = in_r0c1;
  assign m_in[2] = in_r0c2;
  assign m_in[3] = in_r1c0;
  assign m_in[4] = in_r1c1;
  assign m_in[5] = in_r1c2;
  assign m_in[6] = in_r2c0;
  assign m_in[7] = in_r2c1;
  assign m_in[8] = in_r2c2;

  // Stage 1: the eighteen entry products.
  logic signed [W-1:0]  m1 [0:8];
  logic signed [PW-1:0] pa1 [0:8];
  logic signed [PW-1:0] pb1 [0:8];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      m1[k]  <= m_in[k];
      pa1[k] <= m_in[m3inv_pkg::CA[k]] * m_in[m3inv_pkg::CB[k]];
      pb1[k] <= m_in[m3inv_pkg::CC[k]] * m_in[m3inv_pkg::CD[k]];
    end
  end

  // Stage 2: the cofactors.
  logic signed [W-1:0]  m2 [0:8];
  logic signed [CW-1:0] cof2 [0:8];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      m2[k]   <= m1[k];
      cof2[k] <= CW'(pa1[k]) - CW'(pb1[k]);
    end
  end

  // Stage 3: row 0 expansion products for the determinant.
  logic signed [W-1:0]   m3 [0:8];
  logic signed [CW-1:0]  cof3 [0:8];
  logic signed [DPW-1:0] dp3 [0:2];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      m3[k]   <= m2[k];
      cof3[k] <= cof2[k];
    end
    for (int k = 0; k < 3; k++) begin
      dp3[k] <= m2[k] * cof2[k];
    end
  end

  // Stage 4: determinant sum.
  logic signed [W-1:0]    m4 [0:8];
  logic signed [CW-1:0]   cof4 [0:8];
  logic signed [DETW-1:0] det4;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      m4[k]   <= m3[k];
      cof4[k] <= cof3[k];
    end
    det4 <= DETW'(dp3[0]) + DETW'(dp3[1]) + DETW'(dp3[2]);
  end

  // Stage 5: magnitudes and quotient signs; lanes are put in transposed order.
  logic signed [W-1:0] m5 [0:8];
  logic [CMPW-1:0]     an5 [0:8];
  logic [CMPW-1:0]     ad5;
  logic [8:0]          neg5;
  logic                sing5;
  logic [CW-1:0]       acof [0:8];
  logic [DETW-1:0]     adet;

  always_comb begin
    adet = det4[DETW-1] ? DETW'(-det4) : DETW'(det4);
    for (int k = 0; k < 9; k++) begin
      acof[k] = cof4[m3inv_pkg::TR[k]][CW-1] ? CW'(-cof4[m3inv_pkg::TR[k]])
                                             : CW'(cof4[m3inv_pkg::TR[k]]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      m5[k]   <= m4[k];
      an5[k]  <= CMPW'(acof[k]) << (2 * FRAC_BITS);
      neg5[k] <= cof4[m3inv_pkg::TR[k]][CW-1] ^ det4[DETW-1];
    end
    ad5   <= CMPW'(adet);
    sing5 <= (det4 == '0);
  end

  // Divider lanes: stage 0 flags quotients of 2^W or more, then one bit a stage.
  logic [CMPW-1:0]     d_rem [0:W][0:8];
  logic [W-1:0]        d_q   [0:W][0:8];
  logic [8:0]          d_sat [0:W];
  logic [8:0]          d_neg [0:W];
  logic [CMPW-1:0]     d_ad  [0:W];
  logic                d_sing [0:W];
  logic signed [W-1:0] d_m   [0:W][0:8];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      d_rem[0][k] <= an5[k];
      d_q[0][k]   <= '0;
      d_sat[0][k] <= (an5[k] >= (ad5 << W));
      d_m[0][k]   <= m5[k];
    end
    d_neg[0]  <= neg5;
    d_ad[0]   <= ad5;
    d_sing[0] <= sing5;
  end

  for (genvar s = 0; s < W; s++) begin : g_div
    localparam int BIT = W - 1 - s;
    logic [CMPW-1:0] trial;
    logic [8:0]      take;

    // Restoring step: subtract the shifted divisor where it fits.
    always_comb begin
      trial = d_ad[s] << BIT;
      for (int k = 0; k < 9; k++) begin
        take[k] = (d_rem[s][k] >= trial);
      end
    end

    always_ff @(posedge clk) begin
      for (int k = 0; k < 9; k++) begin
        d_rem[s+1][k] <= take[k] ? d_rem[s][k] - trial : d_rem[s][k];
        d_q[s+1][k]   <= d_q[s][k] | (W'(take[k]) << BIT);
        d_m[s+1][k]   <= d_m[s][k];
      end
      d_sat[s+1]  <= d_sat[s];
      d_neg[s+1]  <= d_neg[s];
      d_ad[s+1]   <= d_ad[s];
      d_sing[s+1] <= d_sing[s];
    end
  end

  // Output stage: sign, saturate, or pass the input through when singular.
  logic signed [W-1:0] res [0:8];
  logic signed [W-1:0] outv [0:8];
  logic [W-1:0]        qf;

  always_comb begin
    qf = '0;
    for (int k = 0; k < 9; k++) begin
      qf = d_q[W][k];
      if (!d_neg[W][k]) begin
        if (d_sat[W][k] || qf[W-1]) begin
          res[k] = {1'b0, {(W-1){1'b1}}};
        end else begin
          res[k] = qf;
        end
      end else begin
        if (d_sat[W][k] || (qf[W-1] && (qf[W-2:0] != '0))) begin
          res[k] = {1'b1, {(W-1){1'b0}}};
        end else begin
          res[k] = -qf;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      outv[k] <= d_sing[W] ? d_m[W][k] : res[k];
    end
    singular <= d_sing[W];
  end

  assign out_r0c0 = outv[0];
  assign out_r0c1 = outv[1];
  assign out_r0c2 = outv[2];
  assign out_r1c0 = outv[3];
  assign out_r1c1 = outv[4];
  assign out_r1c2 = outv[5];
  assign out_r2c0 = outv[6];
  assign out_r2c1 = outv[7];
  assign out_r2c2 = outv[8];

  // Every request gives one result on done, and done comes only from a request.
  `M3INV_ASSERT_DELAY(a_latency, start && !busy, NSTG, done)
  `M3INV_ASSERT_IMPLY(a_no_spurious, done, $past(start, NSTG))
  `M3INV_ASSERT_IMPLY(a_singular_pass, done && singular, out_r1c1 == $past(in_r1c1, NSTG))

endmodule
